>>> sv/dq_pkg.sv
`default_nettype none
package dq_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;
  localparam int RADIX   = 16;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } cell_ctl_t;

  typedef struct packed {
    status_t             status;
    logic [COUNT_W-1:0]  count;
    logic                take_back;
    logic                take_front;
    logic [WORD_W-1:0]   front_word;
  } meta_t;

endpackage
`default_nettype wire

>>> sv/dq_cell.sv
`default_nettype none
module dq_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dq_pkg::cell_ctl_t         ctl,
  input  wire logic [dq_pkg::WORD_W-1:0] push_word,
  input  wire logic [dq_pkg::WORD_W-1:0] left_data,
  input  wire logic                      left_valid,
  input  wire logic [dq_pkg::WORD_W-1:0] right_data,
  input  wire logic                      right_valid,
  output logic      [dq_pkg::WORD_W-1:0] data,
  output logic                           valid,
  output logic      [dq_pkg::WORD_W-1:0] sel_word
);

  logic [dq_pkg::WORD_W-1:0] data_r, data_nxt;
  logic                      valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctl.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctl.push_back) begin
      // first empty cell after the occupied run takes the incoming word
      if (!valid_r && left_valid) begin
        data_nxt  = push_word;
        valid_nxt = 1'b1;
      end
    end else if (ctl.pop_back) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data     = data_r;
  assign valid    = valid_r;
  // only the last occupied cell drives its word into the select tree
  assign sel_word = (valid_r && !right_valid) ? data_r : '0;

endmodule
`default_nettype wire

>>> sv/dq_or_stage.sv
`default_nettype none
module dq_or_stage #(
  parameter int N_IN = 16
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [dq_pkg::WORD_W-1:0] in_words  [N_IN],
  output logic      [dq_pkg::WORD_W-1:0] out_words [(N_IN + dq_pkg::RADIX - 1) / dq_pkg::RADIX]
);

  localparam int N_OUT = (N_IN + dq_pkg::RADIX - 1) / dq_pkg::RADIX;

  logic [dq_pkg::WORD_W-1:0] acc   [N_OUT];
  logic [dq_pkg::WORD_W-1:0] out_r [N_OUT];

  // inputs are one-hot at most, so a plain OR selects the word
  always_comb begin
    for (int g = 0; g < N_OUT; g++) begin
      acc[g] = '0;
      for (int m = 0; m < dq_pkg::RADIX; m++) begin
        if (g * dq_pkg::RADIX + m < N_IN) begin
          acc[g] = acc[g] | in_words[g * dq_pkg::RADIX + m];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= acc;
    end
  end

  assign out_words = out_r;

endmodule
`default_nettype wire

>>> sv/double_ended_queue.sv
// Double-ended queue held in a row of shifting cells, front word in cell 0.
// Throughput: one item per cycle, stalled while a result waits on out_ready;
// the row updates in the cycle of acceptance. The result passes through the
// three registered levels of the radix-16 tree that picks the back word.
// Reset (rst_n low, synchronous) empties the queue and the result pipeline;
// word contents are not cleared.
`default_nettype none
module double_ended_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_operation,
  input  wire logic signed [31:0]  in_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_removed_value,
  output logic [4:0]               out_count,
  output logic [1:0]               out_status
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int NG1 = (DEPTH + dq_pkg::RADIX - 1) / dq_pkg::RADIX;
  localparam int NG2 = (NG1 + dq_pkg::RADIX - 1) / dq_pkg::RADIX;

  logic [CW-1:0] count_r, count_nxt;
  logic          v1_r, v2_r, v3_r;
  dq_pkg::meta_t meta1_r, meta2_r, meta3_r, meta_nxt;

  logic              advance, accept, full, empty;
  dq_pkg::op_t       op;
  dq_pkg::cell_ctl_t ctl;
  dq_pkg::status_t   status;
  logic [CW+4:0]     count_ext;

  logic [dq_pkg::WORD_W-1:0] cell_data  [DEPTH];
  logic                      cell_valid [DEPTH];
  logic [dq_pkg::WORD_W-1:0] sel_word   [DEPTH];
  logic [dq_pkg::WORD_W-1:0] lvl1_word  [NG1];
  logic [dq_pkg::WORD_W-1:0] lvl2_word  [NG2];
  logic [dq_pkg::WORD_W-1:0] lvl3_word  [1];

  assign advance  = !v3_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && advance;
  assign op       = dq_pkg::op_t'(in_operation);
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    ctl       = '0;
    status    = dq_pkg::ST_DONE;
    count_nxt = count_r;
    case (op)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = dq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CW'(1);
          if (op == dq_pkg::OP_PUSH_BACK) begin
            ctl.push_back = accept;
          end else begin
            ctl.push_front = accept;
          end
        end
      end
      dq_pkg::OP_POP_BACK, dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          status = dq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
          if (op == dq_pkg::OP_POP_BACK) begin
            ctl.pop_back = accept;
          end else begin
            ctl.pop_front = accept;
          end
        end
      end
      default: begin
        status = dq_pkg::ST_DONE;
      end
    endcase
  end

  assign count_ext = {5'b0, count_nxt};

  always_comb begin
    meta_nxt            = '0;
    meta_nxt.status     = status;
    meta_nxt.count      = count_ext[4:0];
    meta_nxt.take_back  = (op == dq_pkg::OP_POP_BACK) && !empty;
    meta_nxt.take_front = (op == dq_pkg::OP_POP_FRONT) && !empty;
    meta_nxt.front_word = cell_data[0];
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [dq_pkg::WORD_W-1:0] l_data, r_data;
      logic                      l_valid, r_valid;
      // row ends: cell 0 sees the incoming word, the last cell sees an empty neighbor
      if (i == 0) begin : g_first
        assign l_data  = in_value;
        assign l_valid = 1'b1;
      end else begin : g_mid
        assign l_data  = cell_data[i-1];
        assign l_valid = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_inner
        assign r_data  = cell_data[i+1];
        assign r_valid = cell_valid[i+1];
      end
      dq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .push_word   (in_value),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .data        (cell_data[i]),
        .valid       (cell_valid[i]),
        .sel_word    (sel_word[i])
      );
    end
  endgenerate

  dq_or_stage #(.N_IN(DEPTH)) u_lvl1 (
    .clk       (clk),
    .en        (advance),
    .in_words  (sel_word),
    .out_words (lvl1_word)
  );

  dq_or_stage #(.N_IN(NG1)) u_lvl2 (
    .clk       (clk),
    .en        (advance),
    .in_words  (lvl1_word),
    .out_words (lvl2_word)
  );

  dq_or_stage #(.N_IN(NG2)) u_lvl3 (
    .clk       (clk),
    .en        (advance),
    .in_words  (lvl2_word),
    .out_words (lvl3_word)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      meta1_r <= meta_nxt;
      meta2_r <= meta1_r;
      meta3_r <= meta2_r;
    end
    if (!rst_n) begin
      count_r <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (advance) begin
        v1_r <= in_valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  assign out_valid  = v3_r;
  assign out_count  = meta3_r.count;
  assign out_status = meta3_r.status;

  always_comb begin
    if (meta3_r.take_back) begin
      out_removed_value = $signed(lvl3_word[0]);
    end else if (meta3_r.take_front) begin
      out_removed_value = $signed(meta3_r.front_word);
    end else begin
      out_removed_value = '0;
    end
  end

endmodule
`default_nettype wire
